[rtl/eight_bit_cpu_alu_with_flags_macros.svh]
// Assertion macros shared by the ALU RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock outside reset
`define EBALU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expr must hold in the cycle after cond
`define EBALU_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define EBALU_ASSERT(label, clk, rst_n, prop, msg)
`define EBALU_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif

`endif

[rtl/ebalu_pkg.sv]
// Package for the 8-bit CPU ALU: word types, operation codes, constants.
// No dependencies.
`timescale 1ns / 1ps

package ebalu_pkg;

    typedef struct packed {
        logic [5:0]  operation;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic        zero_in;
        logic        subtract_in;
        logic        half_in;
        logic        carry_in;
    } t_alu_in;

    typedef struct packed {
        logic [15:0] result_value;
        logic        zero_out;
        logic        subtract_out;
        logic        half_out;
        logic        carry_out;
    } t_alu_out;

    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_ADC   = 6'd1;
    localparam logic [5:0] OP_SUB   = 6'd2;
    localparam logic [5:0] OP_SBC   = 6'd3;
    localparam logic [5:0] OP_AND   = 6'd4;
    localparam logic [5:0] OP_XOR   = 6'd5;
    localparam logic [5:0] OP_OR    = 6'd6;
    localparam logic [5:0] OP_CP    = 6'd7;
    localparam logic [5:0] OP_INC   = 6'd8;
    localparam logic [5:0] OP_DEC   = 6'd9;
    localparam logic [5:0] OP_RLC   = 6'd10;
    localparam logic [5:0] OP_RRC   = 6'd11;
    localparam logic [5:0] OP_RL    = 6'd12;
    localparam logic [5:0] OP_RR    = 6'd13;
    localparam logic [5:0] OP_RLA   = 6'd14;
    localparam logic [5:0] OP_RRA   = 6'd15;
    localparam logic [5:0] OP_RLCA  = 6'd16;
    localparam logic [5:0] OP_RRCA  = 6'd17;
    localparam logic [5:0] OP_SLA   = 6'd18;
    localparam logic [5:0] OP_SRA   = 6'd19;
    localparam logic [5:0] OP_SRL   = 6'd20;
    localparam logic [5:0] OP_SWAP  = 6'd21;
    localparam logic [5:0] OP_DAA   = 6'd22;
    localparam logic [5:0] OP_CPL   = 6'd23;
    localparam logic [5:0] OP_SCF   = 6'd24;
    localparam logic [5:0] OP_CCF   = 6'd25;
    localparam logic [5:0] OP_BIT   = 6'd26;
    localparam logic [5:0] OP_RES   = 6'd27;
    localparam logic [5:0] OP_SET   = 6'd28;
    localparam logic [5:0] OP_ADD16 = 6'd29;
    localparam logic [5:0] OP_ADDSP = 6'd30;
    localparam logic [5:0] OP_INC16 = 6'd31;
    localparam logic [5:0] OP_DEC16 = 6'd32;

    // BCD correction terms
    localparam logic [7:0] DAA_HI_COR = 8'h60;
    localparam logic [7:0] DAA_LO_COR = 8'h06;
    localparam logic [7:0] DAA_HI_MAX = 8'h99;
    localparam logic [3:0] DAA_LO_MAX = 4'h9;

endpackage

[rtl/eight_bit_cpu_alu_with_flags.sv]
// Top level of the 8-bit CPU ALU: input register, ALU logic, result register.
// Depends on ebalu_pkg and eight_bit_cpu_alu_with_flags_macros.svh.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-------------------------
//  in      | to ALU    | i_in_valid / o_in_stall   | i_in_word  (t_alu_in)
//  out     | from ALU  | o_out_valid / i_out_stall | o_out_word (t_alu_out)
//
// One word per cycle while the output is not stalled; a word passes the input
// register, then one pass of ALU logic, then the result register.
// o_in_stall rises only when both registers are full and the output is stalled.
// Synchronous active-low reset empties both registers; payload is not reset.
`timescale 1ns / 1ps
`include "eight_bit_cpu_alu_with_flags_macros.svh"

module eight_bit_cpu_alu_with_flags (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ebalu_pkg::t_alu_in i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ebalu_pkg::t_alu_out o_out_word
);

    logic                r_in_valid;
    ebalu_pkg::t_alu_in  r_in;
    logic                r_out_valid;
    ebalu_pkg::t_alu_out r_out;
    ebalu_pkg::t_alu_out n_out;

    logic w_adv;     // input stage moves into result stage
    logic w_take;    // new word accepted

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign w_take     = i_in_valid && !o_in_stall;

    // ALU datapath
    logic [7:0] w_a;
    logic [7:0] w_b;
    logic       w_cin;
    logic       w_t;
    logic [8:0] w_sum9;
    logic [4:0] w_hsum;
    logic [8:0] w_dif9;
    logic [4:0] w_hdif;
    logic [7:0] w_r8;
    logic       w_daa_hi;
    logic       w_daa_lo;
    logic [7:0] w_daa_cor;
    logic [16:0] w_sum17;
    logic [12:0] w_sum13;
    logic [15:0] w_ofs;

    always_comb begin
        w_a   = r_in.operand_a[7:0];
        w_b   = r_in.operand_b[7:0];
        w_cin = r_in.carry_in;
        w_t   = ((r_in.operation == ebalu_pkg::OP_ADC) || (r_in.operation == ebalu_pkg::OP_SBC))
                ? w_cin : 1'b0;
        w_sum9 = {1'b0, w_a} + {1'b0, w_b} + {8'd0, w_t};
        w_hsum = {1'b0, w_a[3:0]} + {1'b0, w_b[3:0]} + {4'd0, w_t};
        w_dif9 = {1'b0, w_a} - {1'b0, w_b} - {8'd0, w_t};
        w_hdif = {1'b0, w_a[3:0]} - {1'b0, w_b[3:0]} - {4'd0, w_t};
        w_sum17 = {1'b0, r_in.operand_a} + {1'b0, r_in.operand_b};
        w_sum13 = {1'b0, r_in.operand_a[11:0]} + {1'b0, r_in.operand_b[11:0]};
        w_ofs   = {{8{w_b[7]}}, w_b};

        if (r_in.subtract_in) begin
            w_daa_hi = w_cin;
            w_daa_lo = r_in.half_in;
        end else begin
            w_daa_hi = w_cin || (w_a > ebalu_pkg::DAA_HI_MAX);
            w_daa_lo = r_in.half_in || (w_a[3:0] > ebalu_pkg::DAA_LO_MAX);
        end
        w_daa_cor = (w_daa_hi ? ebalu_pkg::DAA_HI_COR : 8'h00)
                  | (w_daa_lo ? ebalu_pkg::DAA_LO_COR : 8'h00);

        n_out.result_value = {8'h00, w_a};
        n_out.zero_out     = r_in.zero_in;
        n_out.subtract_out = r_in.subtract_in;
        n_out.half_out     = r_in.half_in;
        n_out.carry_out    = w_cin;
        w_r8               = w_a;

        case (r_in.operation)
            ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
                w_r8               = w_sum9[7:0];
                n_out.subtract_out = 1'b0;
                n_out.half_out     = w_hsum[4];
                n_out.carry_out    = w_sum9[8];
                n_out.zero_out     = (w_r8 == 8'h00);
                n_out.result_value = {8'h00, w_r8};
            end
            ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP: begin
                w_r8               = w_dif9[7:0];
                n_out.subtract_out = 1'b1;
                n_out.half_out     = w_hdif[4];
                n_out.carry_out    = w_dif9[8];
                n_out.zero_out     = (w_r8 == 8'h00);
                // compare leaves the accumulator alone
                if (r_in.operation != ebalu_pkg::OP_CP) begin
                    n_out.result_value = {8'h00, w_r8};
                end
            end
            ebalu_pkg::OP_AND, ebalu_pkg::OP_XOR, ebalu_pkg::OP_OR: begin
                if (r_in.operation == ebalu_pkg::OP_AND) begin
                    w_r8 = w_a & w_b;
                end else if (r_in.operation == ebalu_pkg::OP_XOR) begin
                    w_r8 = w_a ^ w_b;
                end else begin
                    w_r8 = w_a | w_b;
                end
                n_out.subtract_out = 1'b0;
                n_out.half_out     = (r_in.operation == ebalu_pkg::OP_AND);
                n_out.carry_out    = 1'b0;
                n_out.zero_out     = (w_r8 == 8'h00);
                n_out.result_value = {8'h00, w_r8};
            end
            ebalu_pkg::OP_INC: begin
                w_r8               = w_a + 8'd1;
                n_out.subtract_out = 1'b0;
                n_out.half_out     = (w_a[3:0] == 4'hF);
                n_out.zero_out     = (w_r8 == 8'h00);
                n_out.result_value = {8'h00, w_r8};
            end
            ebalu_pkg::OP_DEC: begin
                w_r8               = w_a - 8'd1;
                n_out.subtract_out = 1'b1;
                n_out.half_out     = (w_a[3:0] == 4'h0);
                n_out.zero_out     = (w_r8 == 8'h00);
                n_out.result_value = {8'h00, w_r8};
            end
            ebalu_pkg::OP_RLC, ebalu_pkg::OP_RLCA, ebalu_pkg::OP_RRC, ebalu_pkg::OP_RRCA,
            ebalu_pkg::OP_RL, ebalu_pkg::OP_RLA, ebalu_pkg::OP_RR, ebalu_pkg::OP_RRA,
            ebalu_pkg::OP_SLA, ebalu_pkg::OP_SRA, ebalu_pkg::OP_SRL: begin
                case (r_in.operation)
                    ebalu_pkg::OP_RLC, ebalu_pkg::OP_RLCA: begin
                        w_r8 = {w_a[6:0], w_a[7]};
                        n_out.carry_out = w_a[7];
                    end
                    ebalu_pkg::OP_RRC, ebalu_pkg::OP_RRCA: begin
                        w_r8 = {w_a[0], w_a[7:1]};
                        n_out.carry_out = w_a[0];
                    end
                    ebalu_pkg::OP_RL, ebalu_pkg::OP_RLA: begin
                        w_r8 = {w_a[6:0], w_cin};
                        n_out.carry_out = w_a[7];
                    end
                    ebalu_pkg::OP_RR, ebalu_pkg::OP_RRA: begin
                        w_r8 = {w_cin, w_a[7:1]};
                        n_out.carry_out = w_a[0];
                    end
                    ebalu_pkg::OP_SLA: begin
                        w_r8 = {w_a[6:0], 1'b0};
                        n_out.carry_out = w_a[7];
                    end
                    ebalu_pkg::OP_SRA: begin
                        w_r8 = {w_a[7], w_a[7:1]};
                        n_out.carry_out = w_a[0];
                    end
                    default: begin
                        w_r8 = {1'b0, w_a[7:1]};
                        n_out.carry_out = w_a[0];
                    end
                endcase
                n_out.subtract_out = 1'b0;
                n_out.half_out     = 1'b0;
                // accumulator forms always clear Z
                if ((r_in.operation == ebalu_pkg::OP_RLA) ||
                    (r_in.operation == ebalu_pkg::OP_RRA) ||
                    (r_in.operation == ebalu_pkg::OP_RLCA) ||
                    (r_in.operation == ebalu_pkg::OP_RRCA)) begin
                    n_out.zero_out = 1'b0;
                end else begin
                    n_out.zero_out = (w_r8 == 8'h00);
                end
                n_out.result_value = {8'h00, w_r8};
            end
            ebalu_pkg::OP_SWAP: begin
                w_r8               = {w_a[3:0], w_a[7:4]};
                n_out.subtract_out = 1'b0;
                n_out.half_out     = 1'b0;
                n_out.carry_out    = 1'b0;
                n_out.zero_out     = (w_r8 == 8'h00);
                n_out.result_value = {8'h00, w_r8};
            end
            ebalu_pkg::OP_DAA: begin
                if (r_in.subtract_in) begin
                    w_r8 = w_a - w_daa_cor;
                end else begin
                    w_r8 = w_a + w_daa_cor;
                    n_out.carry_out = w_daa_hi;
                end
                n_out.half_out     = 1'b0;
                n_out.zero_out     = (w_r8 == 8'h00);
                n_out.result_value = {8'h00, w_r8};
            end
            ebalu_pkg::OP_CPL: begin
                n_out.result_value = {8'h00, ~w_a};
                n_out.subtract_out = 1'b1;
                n_out.half_out     = 1'b1;
            end
            ebalu_pkg::OP_SCF: begin
                n_out.subtract_out = 1'b0;
                n_out.half_out     = 1'b0;
                n_out.carry_out    = 1'b1;
            end
            ebalu_pkg::OP_CCF: begin
                n_out.subtract_out = 1'b0;
                n_out.half_out     = 1'b0;
                n_out.carry_out    = ~w_cin;
            end
            ebalu_pkg::OP_BIT: begin
                n_out.zero_out     = ~w_a[r_in.bit_index];
                n_out.subtract_out = 1'b0;
                n_out.half_out     = 1'b1;
            end
            ebalu_pkg::OP_RES: begin
                n_out.result_value = {8'h00, w_a & ~(8'h01 << r_in.bit_index)};
            end
            ebalu_pkg::OP_SET: begin
                n_out.result_value = {8'h00, w_a | (8'h01 << r_in.bit_index)};
            end
            ebalu_pkg::OP_ADD16: begin
                n_out.result_value = w_sum17[15:0];
                n_out.subtract_out = 1'b0;
                n_out.half_out     = w_sum13[12];
                n_out.carry_out    = w_sum17[16];
            end
            ebalu_pkg::OP_ADDSP: begin
                // flags come from the unsigned low-byte add
                n_out.result_value = r_in.operand_a + w_ofs;
                n_out.zero_out     = 1'b0;
                n_out.subtract_out = 1'b0;
                n_out.half_out     = w_hsum[4];
                n_out.carry_out    = w_sum9[8];
            end
            ebalu_pkg::OP_INC16: begin
                n_out.result_value = r_in.operand_a + 16'd1;
            end
            ebalu_pkg::OP_DEC16: begin
                n_out.result_value = r_in.operand_a - 16'd1;
            end
            default: begin
                n_out.result_value = r_in.operand_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_take) begin
            r_in <= i_in_word;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `EBALU_ASSERT(a_stall_only_full, i_clk, i_rst_n, !o_in_stall || (r_in_valid && r_out_valid), "input stalled while a register is free")
    `EBALU_ASSERT_NEXT(a_take_lands, i_clk, i_rst_n, w_take, r_in_valid, "accepted word lost from input register")
    `EBALU_ASSERT_NEXT(a_adv_lands, i_clk, i_rst_n, w_adv, r_out_valid, "advanced word missing from result register")
    `EBALU_ASSERT_NEXT(a_blocked_holds, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in), "blocked input word changed")

endmodule

[bench/tb_eight_bit_cpu_alu_with_flags.sv]
// Self-checking testbench for eight_bit_cpu_alu_with_flags: directed and random ALU words,
// bursty input, patterned output stall, every result checked against an in-bench ALU model.
// Depends on ebalu_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_eight_bit_cpu_alu_with_flags;

    localparam logic [5:0] OP_FIRST_UNUSED = ebalu_pkg::OP_DEC16 + 6'd1;
    localparam logic [5:0] OP_CODE_MAX     = 6'd63;
    localparam int RANDOM_WORDS   = 1750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_STALL_RUN  = 6;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    ebalu_pkg::t_alu_in  i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    ebalu_pkg::t_alu_out o_out_word;

    ebalu_pkg::t_alu_in  alu_pending[$];
    ebalu_pkg::t_alu_out alu_expected[$];
    int         drain_marks[$];
    int         n_sent = 0;
    int         n_checked = 0;
    int         n_errors = 0;
    int         n_total = 0;
    int         n_directed = 0;
    int         burst_left = 1;
    int         gap_left = 0;
    bit         hold_now;
    int         mode_left = 0;
    int         stall_run = 0;
    bit         stall_next;
    t_stall_mode stall_mode = STALL_NONE;
    int         idle_cycles = 0;

    eight_bit_cpu_alu_with_flags DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected result of one ALU word
    function automatic ebalu_pkg::t_alu_out alu_result(input ebalu_pkg::t_alu_in w);
        logic [7:0]  a, b, res8;
        logic [15:0] val;
        logic [4:0]  nib;
        logic [8:0]  sum9;
        logic [12:0] sum13;
        logic [16:0] sum17;
        logic        z, n, h, c, cin, t, wide;
        ebalu_pkg::t_alu_out r;
        a = w.operand_a[7:0];
        b = w.operand_b[7:0];
        cin = w.carry_in;
        z = w.zero_in;
        n = w.subtract_in;
        h = w.half_in;
        c = w.carry_in;
        res8 = a;
        val = w.operand_a;
        wide = 1'b0;
        case (w.operation)
            ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
                t = (w.operation == ebalu_pkg::OP_ADC) && cin;
                nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(t);
                sum9 = {1'b0, a} + {1'b0, b} + 9'(t);
                res8 = sum9[7:0];
                z = (res8 == 8'h00);
                n = 1'b0;
                h = nib[4];
                c = sum9[8];
            end
            ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP: begin
                // borrow shows up as the sign bit of the widened difference
                t = (w.operation == ebalu_pkg::OP_SBC) && cin;
                nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(t);
                sum9 = {1'b0, a} - {1'b0, b} - 9'(t);
                z = (sum9[7:0] == 8'h00);
                n = 1'b1;
                h = nib[4];
                c = sum9[8];
                res8 = (w.operation == ebalu_pkg::OP_CP) ? a : sum9[7:0];
            end
            ebalu_pkg::OP_AND: begin
                res8 = a & b;
                z = (res8 == 8'h00);
                n = 1'b0; h = 1'b1; c = 1'b0;
            end
            ebalu_pkg::OP_XOR, ebalu_pkg::OP_OR: begin
                res8 = (w.operation == ebalu_pkg::OP_XOR) ? (a ^ b) : (a | b);
                z = (res8 == 8'h00);
                n = 1'b0; h = 1'b0; c = 1'b0;
            end
            ebalu_pkg::OP_INC: begin
                h = (a[3:0] == 4'hF);
                n = 1'b0;
                res8 = a + 8'd1;
                z = (res8 == 8'h00);
            end
            ebalu_pkg::OP_DEC: begin
                h = (a[3:0] == 4'h0);
                n = 1'b1;
                res8 = a - 8'd1;
                z = (res8 == 8'h00);
            end
            ebalu_pkg::OP_RLC, ebalu_pkg::OP_RLCA: begin
                c = a[7]; res8 = {a[6:0], a[7]};
            end
            ebalu_pkg::OP_RRC, ebalu_pkg::OP_RRCA: begin
                c = a[0]; res8 = {a[0], a[7:1]};
            end
            ebalu_pkg::OP_RL, ebalu_pkg::OP_RLA: begin
                c = a[7]; res8 = {a[6:0], cin};
            end
            ebalu_pkg::OP_RR, ebalu_pkg::OP_RRA: begin
                c = a[0]; res8 = {cin, a[7:1]};
            end
            ebalu_pkg::OP_SLA:  begin c = a[7]; res8 = {a[6:0], 1'b0}; end
            ebalu_pkg::OP_SRA:  begin c = a[0]; res8 = {a[7], a[7:1]}; end
            ebalu_pkg::OP_SRL:  begin c = a[0]; res8 = {1'b0, a[7:1]}; end
            ebalu_pkg::OP_SWAP: begin c = 1'b0; res8 = {a[3:0], a[7:4]}; end
            ebalu_pkg::OP_DAA: begin
                res8 = a;
                if (!w.subtract_in) begin
                    if (cin || a > ebalu_pkg::DAA_HI_MAX) begin
                        res8 = res8 + ebalu_pkg::DAA_HI_COR;
                        c = 1'b1;
                    end
                    if (w.half_in || res8[3:0] > ebalu_pkg::DAA_LO_MAX)
                        res8 = res8 + ebalu_pkg::DAA_LO_COR;
                end else begin
                    if (cin)
                        res8 = res8 - ebalu_pkg::DAA_HI_COR;
                    if (w.half_in)
                        res8 = res8 - ebalu_pkg::DAA_LO_COR;
                end
                z = (res8 == 8'h00);
                h = 1'b0;
            end
            ebalu_pkg::OP_CPL: begin res8 = ~a; n = 1'b1; h = 1'b1; end
            ebalu_pkg::OP_SCF: begin n = 1'b0; h = 1'b0; c = 1'b1; end
            ebalu_pkg::OP_CCF: begin n = 1'b0; h = 1'b0; c = ~cin; end
            ebalu_pkg::OP_BIT: begin
                z = ~a[w.bit_index];
                n = 1'b0;
                h = 1'b1;
            end
            ebalu_pkg::OP_RES: res8 = a & ~(8'h01 << w.bit_index);
            ebalu_pkg::OP_SET: res8 = a | (8'h01 << w.bit_index);
            ebalu_pkg::OP_ADD16: begin
                sum13 = {1'b0, w.operand_a[11:0]} + {1'b0, w.operand_b[11:0]};
                sum17 = {1'b0, w.operand_a} + {1'b0, w.operand_b};
                n = 1'b0;
                h = sum13[12];
                c = sum17[16];
                val = sum17[15:0];
                wide = 1'b1;
            end
            ebalu_pkg::OP_ADDSP: begin
                // flags come from the unsigned low-byte add, value from the signed offset
                nib = {1'b0, w.operand_a[3:0]} + {1'b0, b[3:0]};
                sum9 = {1'b0, w.operand_a[7:0]} + {1'b0, b};
                z = 1'b0; n = 1'b0;
                h = nib[4];
                c = sum9[8];
                val = w.operand_a + {{8{b[7]}}, b};
                wide = 1'b1;
            end
            ebalu_pkg::OP_INC16: begin val = w.operand_a + 16'd1; wide = 1'b1; end
            ebalu_pkg::OP_DEC16: begin val = w.operand_a - 16'd1; wide = 1'b1; end
            default:  wide = 1'b1;
        endcase
        if (w.operation >= ebalu_pkg::OP_RLC && w.operation <= ebalu_pkg::OP_SWAP) begin
            z = (res8 == 8'h00);
            n = 1'b0;
            h = 1'b0;
        end
        if (w.operation >= ebalu_pkg::OP_RLA && w.operation <= ebalu_pkg::OP_RRCA)
            z = 1'b0;
        r.result_value = wide ? val : {8'h00, res8};
        r.zero_out = z;
        r.subtract_out = n;
        r.half_out = h;
        r.carry_out = c;
        return r;
    endfunction

    task automatic add_word(input logic [5:0] op, input logic [15:0] a, input logic [15:0] b,
                            input logic [2:0] bi, input logic [3:0] znhc);
        alu_pending.push_back({op, a, b, bi, znhc});
    endtask

    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        if ($urandom_range(0, 3) != 0)
            return 16'($urandom);
        case ($urandom_range(0, 8))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'h00FF;
            3: v = 16'h0080;
            4: v = 16'h007F;
            5: v = 16'h0FFF;
            6: v = 16'h8000;
            7: v = 16'h0099;
            default: v = 16'hF00F;
        endcase
        return v;
    endfunction

    // Input side: bursts with gaps, pauses at drain marks until everything is back
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                alu_expected.push_back(alu_result(i_in_word));
                n_sent++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                hold_now = (drain_marks.size() != 0) && (n_sent == drain_marks[0]);
                if (hold_now && n_checked == n_sent) begin
                    void'(drain_marks.pop_front());
                    hold_now = 1'b0;
                end
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (hold_now || alu_pending.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_word <= alu_pending.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Output side: check each accepted word, stall on a pattern that shifts over time
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (alu_expected.size() == 0) begin
                    $error("unexpected result word %h", o_out_word);
                    n_errors++;
                end else begin
                    ebalu_pkg::t_alu_out exp_w;
                    exp_w = alu_expected.pop_front();
                    if (o_out_word.result_value !== exp_w.result_value) begin
                        $error("result_value: expected %h, got %h",
                               exp_w.result_value, o_out_word.result_value);
                        n_errors++;
                    end
                    if (o_out_word.zero_out !== exp_w.zero_out) begin
                        $error("zero_out: expected %b, got %b",
                               exp_w.zero_out, o_out_word.zero_out);
                        n_errors++;
                    end
                    if (o_out_word.subtract_out !== exp_w.subtract_out) begin
                        $error("subtract_out: expected %b, got %b",
                               exp_w.subtract_out, o_out_word.subtract_out);
                        n_errors++;
                    end
                    if (o_out_word.half_out !== exp_w.half_out) begin
                        $error("half_out: expected %b, got %b",
                               exp_w.half_out, o_out_word.half_out);
                        n_errors++;
                    end
                    if (o_out_word.carry_out !== exp_w.carry_out) begin
                        $error("carry_out: expected %b, got %b",
                               exp_w.carry_out, o_out_word.carry_out);
                        n_errors++;
                    end
                    n_checked <= n_checked + 1;
                end
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:  stall_next = 1'b0;
                STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                default:     stall_next = ~i_out_stall;
            endcase
            if (stall_run >= MAX_STALL_RUN)
                stall_next = 1'b0;
            stall_run = stall_next ? stall_run + 1 : 0;
            i_out_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [5:0] op;
        // flag argument order is Z N H C
        add_word(ebalu_pkg::OP_ADD,   16'hA5FF, 16'h5A01, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_ADC,   16'h000F, 16'h0000, 3'd0, 4'b0001);
        add_word(ebalu_pkg::OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_SBC,   16'h0010, 16'h000F, 3'd0, 4'b0001);
        add_word(ebalu_pkg::OP_AND,   16'hFFFF, 16'hFF00, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_XOR,   16'h00AA, 16'h0055, 3'd0, 4'b1111);
        add_word(ebalu_pkg::OP_OR,    16'h0000, 16'h0000, 3'd0, 4'b1111);
        add_word(ebalu_pkg::OP_CP,    16'hC33C, 16'h003C, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_INC,   16'h00FF, 16'h0000, 3'd0, 4'b0001);
        add_word(ebalu_pkg::OP_DEC,   16'h0010, 16'h0000, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_RLC,   16'h0080, 16'h0000, 3'd0, 4'b1110);
        add_word(ebalu_pkg::OP_RRC,   16'h0001, 16'h0000, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_RL,    16'h0080, 16'h0000, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_RR,    16'h0001, 16'h0000, 3'd0, 4'b0001);
        add_word(ebalu_pkg::OP_RLA,   16'h0000, 16'h0000, 3'd0, 4'b1000);
        add_word(ebalu_pkg::OP_RRA,   16'h0001, 16'h0000, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_RLCA,  16'h0080, 16'h0000, 3'd0, 4'b1111);
        add_word(ebalu_pkg::OP_RRCA,  16'h0001, 16'h0000, 3'd0, 4'b1111);
        add_word(ebalu_pkg::OP_SLA,   16'h0080, 16'h0000, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_SRA,   16'h0081, 16'h0000, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_SRL,   16'h0001, 16'h0000, 3'd0, 4'b0110);
        add_word(ebalu_pkg::OP_SWAP,  16'h00F0, 16'h0000, 3'd0, 4'b0111);
        add_word(ebalu_pkg::OP_DAA,   16'h009A, 16'h0000, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_DAA,   16'h0000, 16'h0000, 3'd0, 4'b0111);
        add_word(ebalu_pkg::OP_CPL,   16'h0000, 16'h0000, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_SCF,   16'h0042, 16'h0000, 3'd0, 4'b0110);
        add_word(ebalu_pkg::OP_CCF,   16'h0042, 16'h0000, 3'd0, 4'b1111);
        add_word(ebalu_pkg::OP_BIT,   16'h007F, 16'h0000, 3'd7, 4'b0000);
        add_word(ebalu_pkg::OP_BIT,   16'h0080, 16'h0000, 3'd7, 4'b1001);
        add_word(ebalu_pkg::OP_RES,   16'hFFFF, 16'h0000, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_SET,   16'h0000, 16'h0000, 3'd7, 4'b0000);
        add_word(ebalu_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'b1000);
        add_word(ebalu_pkg::OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_ADDSP, 16'h00FF, 16'h0001, 3'd0, 4'b1111);
        add_word(ebalu_pkg::OP_ADDSP, 16'hFFF8, 16'hFF80, 3'd0, 4'b0000);
        add_word(ebalu_pkg::OP_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'b1111);
        add_word(ebalu_pkg::OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'b0000);
        add_word(OP_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7, 4'b1111);
        add_word(OP_CODE_MAX,     16'h1234, 16'h0000, 3'd0, 4'b0101);
        n_directed = alu_pending.size();

        // mostly defined operations, some unused codes mixed in
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if ($urandom_range(0, 9) == 0)
                op = 6'($urandom_range(OP_FIRST_UNUSED, OP_CODE_MAX));
            else
                op = 6'($urandom_range(ebalu_pkg::OP_ADD, ebalu_pkg::OP_DEC16));
            add_word(op, pick_operand(), pick_operand(), 3'($urandom_range(0, 7)),
                     4'($urandom_range(0, 15)));
        end
        n_total = alu_pending.size();
        drain_marks.push_back(n_directed);
        drain_marks.push_back(n_directed + RANDOM_WORDS / 2);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_checked == n_total);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d ALU words (%0d directed, rest random): all defined operations",
                 n_checked, n_directed);
        $display("plus unused codes, bursty input, varied output stall, two drains; %0d mismatches.",
                 n_errors);
        if (n_errors == 0 && alu_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
